### src/zrbc_pkg.sv
// Shared types and constants for the zero-run byte compressor.
`timescale 1ns / 1ps

package zrbc_pkg;

    localparam logic [7:0] RUN_MAX   = 8'd255;
    localparam logic [7:0] ZERO_MARK = 8'd0;

    // One classified input: one or two output bytes plus the block-end flag
    typedef struct packed {
        logic       two;
        logic [7:0] b0;
        logic [7:0] b1;
        logic       last;
    } t_cmd;

endpackage

### src/zrbc_front.sv
// Front end: accepts input bytes, tracks the zero run, builds output commands.
`timescale 1ns / 1ps

module zrbc_front
    import zrbc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    input  logic       i_q_full,
    output logic       o_q_push,
    output t_cmd       o_q_cmd
);

    logic       r_run;
    logic [7:0] r_len;
    logic       n_run;
    logic [7:0] n_len;
    logic       accept;
    logic       emit;
    t_cmd       cmd;

    assign full   = i_q_full;
    assign accept = push && !i_q_full;

    always_comb begin
        n_run    = r_run;
        n_len    = r_len;
        emit     = 1'b0;
        cmd.two  = 1'b0;
        cmd.b0   = i_in_byte;
        cmd.b1   = i_in_byte;
        cmd.last = i_in_last;

        if (i_in_byte != ZERO_MARK) begin
            emit  = 1'b1;
            if (r_run) begin
                cmd.two = 1'b1;
                cmd.b0  = r_len;
            end
            n_run = 1'b0;
            n_len = 8'd0;
        end else if (r_run) begin
            if (r_len == RUN_MAX - 8'd1) begin
                emit   = 1'b1;
                cmd.b0 = RUN_MAX;
                n_run  = 1'b0;
                n_len  = 8'd0;
            end else begin
                n_len = r_len + 8'd1;
            end
        end else begin
            emit   = 1'b1;
            cmd.b0 = ZERO_MARK;
            n_run  = 1'b1;
            n_len  = 8'd1;
        end

        // block end flushes a still-open run count
        if (i_in_last) begin
            if (n_run) begin
                if (emit) begin
                    cmd.two = 1'b1;
                    cmd.b1  = n_len;
                end else begin
                    cmd.b0 = n_len;
                end
                emit = 1'b1;
            end
            n_run = 1'b0;
            n_len = 8'd0;
        end
    end

    assign o_q_push = accept && emit;
    assign o_q_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_len <= 8'd0;
        end else if (accept) begin
            r_run <= n_run;
            r_len <= n_len;
        end
    end

endmodule

### src/zrbc_queue.sv
// Short command queue between front and back ends.
`timescale 1ns / 1ps

module zrbc_queue
    import zrbc_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_nonempty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full     = (r_cnt == FULL_CNT);
    assign o_nonempty = (r_cnt != '0);
    assign o_cmd      = r_mem[r_rd];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

### src/zrbc_back.sv
// Back end: serialises commands into output beats through an output register.
`timescale 1ns / 1ps

module zrbc_back
    import zrbc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic       i_q_nonempty,
    output logic       o_q_pop,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    logic r_valid;
    logic r_idx;
    t_cmd r_cmd;
    logic fin;
    logic take;
    logic load;

    // second byte of a pair, or the only byte, closes the command
    assign fin  = r_idx || !r_cmd.two;
    assign take = pop && r_valid;
    assign load = i_q_nonempty && (!r_valid || (take && fin));

    assign o_q_pop    = load;
    assign empty      = !r_valid;
    assign o_out_byte = r_idx ? r_cmd.b1 : r_cmd.b0;
    assign o_out_last = fin && r_cmd.last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= 1'b0;
        end else if (take) begin
            if (fin) begin
                r_valid <= 1'b0;
                r_idx   <= 1'b0;
            end else begin
                r_idx <= 1'b1;
            end
        end
    end

endmodule

### src/zero_run_byte_compressor.sv
// Top level of the zero-run byte compressor.
// Input channel: push/full with i_in_byte and i_in_last; a beat is taken when
//   push is high and full is low. i_in_last marks the final byte of a block.
// Output channel: empty/pop with o_out_byte and o_out_last; the oldest byte is
//   shown while empty is low and leaves on a cycle with pop high.
// A nonzero byte passes as a literal; a zero run becomes a zero marker and a
// count of 1..255. A count of 255 closes the run. o_out_last flags the final
// output byte of each compressed block.
// Each input beat yields zero, one or two output beats. The front end takes
// one beat per cycle while the command queue has room; the output register
// emits one beat per cycle while pop is high, so sustained rate is one output
// byte per cycle and the queue fills when every input makes two bytes.
// An input byte passes through the queue and then the output register.
// Reset clears the run state, the queue and the output register. When the
// receiver stalls, the queue of QDEPTH commands fills and full rises; no beat
// is lost.
`timescale 1ns / 1ps

module zero_run_byte_compressor
    import zrbc_pkg::*;
#(
    parameter int QDEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_nonempty;
    t_cmd q_in;
    t_cmd q_out;

    zrbc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_q_cmd   (q_in)
    );

    zrbc_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_cmd      (q_in),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_cmd      (q_out),
        .o_nonempty (q_nonempty)
    );

    zrbc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (q_out),
        .i_q_nonempty (q_nonempty),
        .o_q_pop      (q_pop),
        .empty        (empty),
        .pop          (pop),
        .o_out_byte   (o_out_byte),
        .o_out_last   (o_out_last)
    );

endmodule
